FILE: rtl/core/tcm_pkg.sv
// Package for the triple-DES CBC-MAC block with derived keys.
// Holds the DES tables, permutation and round functions, register codes and stage types.
// No dependencies.
package tcm_pkg;

  localparam int DES_ROUNDS = 16;
  localparam int MAC_OPS = 9;
  localparam int NUM_KEYS = 3;

  localparam logic [2:0] REG_SEED_KEY_ONE = 3'd0;
  localparam logic [2:0] REG_SEED_KEY_TWO = 3'd1;
  localparam logic [2:0] REG_SEED_KEY_THREE = 3'd2;
  localparam logic [2:0] REG_PRODUCT_IDENT = 3'd3;
  localparam logic [2:0] REG_INITIAL_VECTOR = 3'd4;

  localparam int IP_TAB [64] = '{
    58,50,42,34,26,18,10,2,60,52,44,36,28,20,12,4,
    62,54,46,38,30,22,14,6,64,56,48,40,32,24,16,8,
    57,49,41,33,25,17,9,1,59,51,43,35,27,19,11,3,
    61,53,45,37,29,21,13,5,63,55,47,39,31,23,15,7};
  localparam int FP_TAB [64] = '{
    40,8,48,16,56,24,64,32,39,7,47,15,55,23,63,31,
    38,6,46,14,54,22,62,30,37,5,45,13,53,21,61,29,
    36,4,44,12,52,20,60,28,35,3,43,11,51,19,59,27,
    34,2,42,10,50,18,58,26,33,1,41,9,49,17,57,25};
  localparam int E_TAB [48] = '{
    32,1,2,3,4,5,4,5,6,7,8,9,8,9,10,11,12,13,12,13,14,15,16,17,
    16,17,18,19,20,21,20,21,22,23,24,25,24,25,26,27,28,29,28,29,30,31,32,1};
  localparam int P_TAB [32] = '{
    16,7,20,21,29,12,28,17,1,15,23,26,5,18,31,10,
    2,8,24,14,32,27,3,9,19,13,30,6,22,11,4,25};
  localparam int PC1_TAB [56] = '{
    57,49,41,33,25,17,9,1,58,50,42,34,26,18,10,2,59,51,43,35,27,19,11,3,60,52,44,36,
    63,55,47,39,31,23,15,7,62,54,46,38,30,22,14,6,61,53,45,37,29,21,13,5,28,20,12,4};
  localparam int PC2_TAB [48] = '{
    14,17,11,24,1,5,3,28,15,6,21,10,23,19,12,4,26,8,16,7,27,20,13,2,
    41,52,31,37,47,55,30,40,51,45,33,48,44,49,39,56,34,53,46,42,50,36,29,32};
  localparam int KEY_SHIFT [16] = '{1,2,4,6,8,10,12,14,15,17,19,21,23,25,27,28};

  localparam logic [3:0] SBOX [8][64] = '{
    '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
      4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
    '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
      0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
    '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
      13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
    '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
      10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
    '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
      4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
    '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
      9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
    '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
      1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
    '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
      7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

  typedef struct packed {
    logic valid;
    logic [NUM_KEYS-1:0][31:0] l;
    logic [NUM_KEYS-1:0][31:0] r;
    logic [NUM_KEYS-1:0][63:0] blk;
  } kd_t;

  function automatic logic [63:0] ip_perm(input logic [63:0] v);
    logic [63:0] o;
    for (int i = 0; i < 64; i++) o[63-i] = v[64-IP_TAB[i]];
    return o;
  endfunction

  function automatic logic [63:0] fp_perm(input logic [63:0] v);
    logic [63:0] o;
    for (int i = 0; i < 64; i++) o[63-i] = v[64-FP_TAB[i]];
    return o;
  endfunction

  function automatic logic [55:0] pc1_perm(input logic [63:0] v);
    logic [55:0] o;
    for (int i = 0; i < 56; i++) o[55-i] = v[64-PC1_TAB[i]];
    return o;
  endfunction

  function automatic logic [27:0] rotl28(input logic [27:0] x, input int sh);
    logic [55:0] t;
    t = {x, x} << sh;
    return t[55:28];
  endfunction

  function automatic logic [47:0] subkey(input logic [55:0] cd, input int sh);
    logic [55:0] rot;
    logic [47:0] o;
    rot = {rotl28(cd[55:28], sh), rotl28(cd[27:0], sh)};
    for (int i = 0; i < 48; i++) o[47-i] = rot[56-PC2_TAB[i]];
    return o;
  endfunction

  function automatic logic [31:0] feistel(input logic [31:0] r, input logic [47:0] k);
    logic [47:0] x;
    logic [5:0] b;
    logic [31:0] s;
    logic [31:0] o;
    for (int i = 0; i < 48; i++) x[47-i] = r[32-E_TAB[i]];
    x = x ^ k;
    for (int i = 0; i < 8; i++) begin
      b = x[47-6*i -: 6];
      s[31-4*i -: 4] = SBOX[i][{b[5], b[0], b[4:1]}];
    end
    for (int i = 0; i < 32; i++) o[31-i] = s[32-P_TAB[i]];
    return o;
  endfunction

endpackage

FILE: rtl/core/tcm_in_if.sv
// Input channel interface carrying the three MAC blocks.
// Depends on nothing.
interface tcm_in_if;
  logic valid;
  logic ready;
  logic [63:0] seq_number;
  logic [63:0] load_value;
  logic [63:0] card_random;
  modport source (output valid, seq_number, load_value, card_random, input ready);
  modport sink (input valid, seq_number, load_value, card_random, output ready);
endinterface

FILE: rtl/core/tcm_out_if.sv
// Output channel interface carrying the authentication code.
// Depends on nothing.
interface tcm_out_if;
  logic valid;
  logic ready;
  logic [63:0] auth_code;
  modport source (output valid, auth_code, input ready);
  modport sink (input valid, auth_code, output ready);
endinterface

FILE: rtl/core/tcm_round.sv
// One registered DES Feistel round cell.
// Depends on tcm_pkg.
module tcm_round (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] l_in,
  input  logic [31:0] r_in,
  input  logic [47:0] key,
  output logic [31:0] l_out,
  output logic [31:0] r_out
);
  import tcm_pkg::*;

  always_ff @(posedge clk) begin
    if (en) begin
      l_out <= r_in;
      r_out <= l_in ^ feistel(r_in, key);
    end
  end
endmodule

FILE: rtl/core/tcm_kdrv.sv
// Session key derivation: three parallel rows of round cells decrypting the product identifier.
// Depends on tcm_pkg and tcm_round.
module tcm_kdrv (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [2:0][63:0]     in_blk,
  input  logic [2:0][63:0]     seed_key,
  input  logic [63:0]          product_ident,
  output tcm_pkg::kd_t         kd
);
  import tcm_pkg::*;

  logic [63:0] pid_ip;
  logic [NUM_KEYS-1:0][55:0] seed_cd;
  logic [31:0] l_q [DES_ROUNDS][NUM_KEYS];
  logic [31:0] r_q [DES_ROUNDS][NUM_KEYS];
  logic [2:0][63:0] blk_q [DES_ROUNDS];
  logic v_q [DES_ROUNDS];

  assign pid_ip = ip_perm(product_ident);

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_cd
    assign seed_cd[k] = pc1_perm(seed_key[k]);
  end

  for (genvar s = 0; s < DES_ROUNDS; s++) begin : g_stage
    logic [2:0][63:0] bi;
    logic vi;
    if (s == 0) begin : g_first
      assign bi = in_blk;
      assign vi = in_valid;
    end else begin : g_next
      assign bi = blk_q[s-1];
      assign vi = v_q[s-1];
    end

    for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
      logic [31:0] li;
      logic [31:0] ri;
      if (s == 0) begin : g_src0
        assign li = pid_ip[63:32];
        assign ri = pid_ip[31:0];
      end else begin : g_srcn
        assign li = l_q[s-1][k];
        assign ri = r_q[s-1][k];
      end
      tcm_round u_round (
        .clk   (clk),
        .en    (en),
        .l_in  (li),
        .r_in  (ri),
        .key   (subkey(seed_cd[k], KEY_SHIFT[DES_ROUNDS-1-s])),
        .l_out (l_q[s][k]),
        .r_out (r_q[s][k])
      );
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[s] <= 1'b0;
      end else if (en) begin
        v_q[s] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        blk_q[s] <= bi;
      end
    end
  end

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_out
    assign kd.l[k] = l_q[DES_ROUNDS-1][k];
    assign kd.r[k] = r_q[DES_ROUNDS-1][k];
  end
  assign kd.blk = blk_q[DES_ROUNDS-1];
  assign kd.valid = v_q[DES_ROUNDS-1];
endmodule

FILE: rtl/core/tcm_mac.sv
// CBC-MAC chain: nine DES operations of sixteen round cells each, encrypt-decrypt-encrypt per block.
// Depends on tcm_pkg and tcm_round.
module tcm_mac (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  tcm_pkg::kd_t kd,
  input  logic [63:0]  initial_vector,
  output logic         out_valid,
  output logic [63:0]  auth_code
);
  import tcm_pkg::*;

  localparam int STAGES = MAC_OPS * DES_ROUNDS;

  logic [31:0] l_q [STAGES];
  logic [31:0] r_q [STAGES];
  logic [NUM_KEYS-1:0][55:0] k_q [STAGES];
  logic [2:0][63:0] blk_q [STAGES];
  logic v_q [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    localparam int J = s / DES_ROUNDS;
    localparam int I = s % DES_ROUNDS;
    localparam int KSEL = J % NUM_KEYS;
    localparam int SH = (KSEL == 1) ? KEY_SHIFT[DES_ROUNDS-1-I] : KEY_SHIFT[I];

    logic [NUM_KEYS-1:0][55:0] ki;
    logic [2:0][63:0] bi;
    logic vi;
    logic [31:0] li;
    logic [31:0] ri;
    logic [63:0] xin;

    if (s == 0) begin : g_first
      for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
        assign ki[k] = pc1_perm(fp_perm({kd.r[k], kd.l[k]}));
      end
      assign bi = kd.blk;
      assign vi = kd.valid;
      assign xin = ip_perm(kd.blk[0] ^ initial_vector);
      assign li = xin[63:32];
      assign ri = xin[31:0];
    end else begin : g_next
      assign ki = k_q[s-1];
      assign bi = blk_q[s-1];
      assign vi = v_q[s-1];
      if (I == 0 && KSEL == 0) begin : g_chain
        assign xin = ip_perm(fp_perm({r_q[s-1], l_q[s-1]}) ^ blk_q[s-1][J/NUM_KEYS]);
        assign li = xin[63:32];
        assign ri = xin[31:0];
      end else if (I == 0) begin : g_op
        assign xin = {r_q[s-1], l_q[s-1]};
        assign li = xin[63:32];
        assign ri = xin[31:0];
      end else begin : g_round
        assign xin = {l_q[s-1], r_q[s-1]};
        assign li = xin[63:32];
        assign ri = xin[31:0];
      end
    end

    tcm_round u_round (
      .clk   (clk),
      .en    (en),
      .l_in  (li),
      .r_in  (ri),
      .key   (subkey(ki[KSEL], SH)),
      .l_out (l_q[s]),
      .r_out (r_q[s])
    );

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[s] <= 1'b0;
      end else if (en) begin
        v_q[s] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        k_q[s] <= ki;
        blk_q[s] <= bi;
      end
    end
  end

  assign out_valid = v_q[STAGES-1];
  assign auth_code = fp_perm({r_q[STAGES-1], l_q[STAGES-1]});
endmodule

FILE: rtl/core/tdes_cbc_mac_with_derived_keys_top.sv
// Top level of the triple-DES CBC-MAC block with derived session keys.
// Depends on tcm_pkg, tcm_in_if, tcm_out_if, tcm_kdrv and tcm_mac.
//
//   Channel   Kind          Contents
//   mac_in    valid/ready   seq_number, load_value, card_random
//   mac_out   valid/ready   auth_code
//   APB       write/read    five 64-bit registers at byte addresses 0, 8, 16, 24, 32
//
// One transfer is accepted every cycle unless mac_out holds an untaken result;
// each result passes through 16 key derivation cells, then 144 MAC round cells.
// Reset clears only the stage valid bits and the registers.
// While a result waits untaken at mac_out, the whole chain of cells holds.
module tdes_cbc_mac_with_derived_keys_top (
  input  logic        clk,
  input  logic        rst,
  tcm_in_if.sink      mac_in,
  tcm_out_if.source   mac_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import tcm_pkg::*;

  logic [63:0] seed_key_one;
  logic [63:0] seed_key_two;
  logic [63:0] seed_key_three;
  logic [63:0] product_ident;
  logic [63:0] initial_vector;
  logic [2:0] reg_idx;
  logic en;
  kd_t kd;

  assign pready = 1'b1;
  assign reg_idx = paddr[5:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_key_one <= '0;
      seed_key_two <= '0;
      seed_key_three <= '0;
      product_ident <= '0;
      initial_vector <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_SEED_KEY_ONE:   seed_key_one <= pwdata;
        REG_SEED_KEY_TWO:   seed_key_two <= pwdata;
        REG_SEED_KEY_THREE: seed_key_three <= pwdata;
        REG_PRODUCT_IDENT:  product_ident <= pwdata;
        REG_INITIAL_VECTOR: initial_vector <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SEED_KEY_ONE:   prdata = seed_key_one;
      REG_SEED_KEY_TWO:   prdata = seed_key_two;
      REG_SEED_KEY_THREE: prdata = seed_key_three;
      REG_PRODUCT_IDENT:  prdata = product_ident;
      REG_INITIAL_VECTOR: prdata = initial_vector;
      default:            prdata = '0;
    endcase
  end

  assign en = !mac_out.valid || mac_out.ready;
  assign mac_in.ready = en;

  tcm_kdrv u_kdrv (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .in_valid      (mac_in.valid),
    .in_blk        ({mac_in.card_random, mac_in.load_value, mac_in.seq_number}),
    .seed_key      ({seed_key_three, seed_key_two, seed_key_one}),
    .product_ident (product_ident),
    .kd            (kd)
  );

  tcm_mac u_mac (
    .clk            (clk),
    .rst            (rst),
    .en             (en),
    .kd             (kd),
    .initial_vector (initial_vector),
    .out_valid      (mac_out.valid),
    .auth_code      (mac_out.auth_code)
  );
endmodule
